[src/assert_macros.svh]
// assertion helpers for the multi timer pool
// expects clk_i and rst_ni in the scope of the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define TMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen outside reset
`define TMP_ASSERT_NEVER(lbl, cond, msg) \
  `TMP_ASSERT(lbl, !(cond), msg)

`endif

[src/tmp_pkg.sv]
// shared types, codes and constants of the multi timer pool
// no dependencies; used by every module of the block
`default_nettype none

package tmp_pkg;

  // pool geometry and timing base
  localparam int NUM_TIMERS   = 16;
  localparam int TICKS_PER_MS = 100;
  localparam int ADDR_LIMIT   = 16;
  localparam int SLOT_LIMIT   = (NUM_TIMERS < ADDR_LIMIT) ? NUM_TIMERS : ADDR_LIMIT;

  // field widths
  localparam int REQ_W      = 3;
  localparam int ID_W       = 4;
  localparam int MS_W       = 24;
  localparam int NOW_W      = 32;
  localparam int TICK_W     = 31;
  localparam int STAT_W     = 2;
  localparam int LEFT_W     = 24;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;

  // walk counter size
  localparam int CNT_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // rounded-up reciprocal of TICKS_PER_MS, exact for any TICK_W-bit dividend
  localparam int DIV_SHIFT = TICK_W + $clog2(TICKS_PER_MS);
  localparam int DIV_M_W   = TICK_W + 1;
  localparam logic [DIV_M_W-1:0] DIV_MAGIC =
    DIV_M_W'(((64'd1 << DIV_SHIFT) + 64'(TICKS_PER_MS - 1)) / 64'(TICKS_PER_MS));

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 3'd0,
    REQ_ALLOC = 3'd1,
    REQ_FREE  = 3'd2,
    REQ_START = 3'd3,
    REQ_STOP  = 3'd4,
    REQ_QUERY = 3'd5
  } req_e;

  // response status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } stat_e;

  // result kinds
  localparam logic KIND_RESP   = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // control sequencer states
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WALK   = 5'b00010,
    S_DSTART = 5'b00100,
    S_DIV    = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  // one timer slot as held in a cell
  typedef struct packed {
    logic              used;
    logic              periodic;
    logic [TICK_W-1:0] total;
    logic [TICK_W-1:0] rem;
  } slot_rec_t;

  // command held for the length of one walk
  typedef struct packed {
    req_e              req;
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] ticks;
    logic              mode;
    logic [NOW_W-1:0]  elapsed;
  } cmd_t;

  // outcome of processing the head cell
  typedef struct packed {
    slot_rec_t rec;
    logic      match;
    logic      grab;
    logic      expire;
  } step_t;

endpackage

`default_nettype wire

[src/multi_timer_pool_unit.sv]
// top level of the multi timer pool: ring of slot cells, head update unit,
// reciprocal divider and output register; depends on tmp_pkg and the cell modules
//
//  channel  | dir | handshake                    | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser req_type, tdata command fields
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tuser result_kind, tdata result, tlast
//
// every item walks the ring of NUM_TIMERS cells once, one slot per cycle
// while the ring is not held; after the walk a query also runs the
// reciprocal divide; a tick whose count is unchanged finishes on accept
// expiry events leave one per slot; a stalled output holds the ring on a new expiry
// reset clears all cells at once, no clearing pass is needed
`default_nettype none

module multi_timer_pool_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [3:0] timer_id, [27:4] duration_ms, [28] reload_mode, [60:29] now_tick
  input  logic [tmp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [2:0] req_type
  input  logic [tmp_pkg::REQ_W-1:0]      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [3:0] slot_id, [5:4] status, [6] is_running, [30:7] left_ms
  output logic [tmp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [0] result_kind
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);
  import tmp_pkg::*;

  `include "assert_macros.svh"

  state_e            state_q;
  cmd_t              cmd_q;
  logic [NOW_W-1:0]  prev_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              found_q;
  logic [ID_W-1:0]   found_id_q;
  logic              valid_q;
  logic              run_q;
  logic [TICK_W-1:0] rem_cap_q;
  logic              pend_v_q;
  logic [ID_W-1:0]   pend_id_q;

  logic              out_valid_q;
  logic              out_kind_q;
  logic [ID_W-1:0]   out_slot_q;
  stat_e             out_status_q;
  logic              out_run_q;
  logic [LEFT_W-1:0] out_left_q;
  logic              out_last_q;

  // input fields
  logic [REQ_W-1:0]  in_req;
  logic [ID_W-1:0]   in_id;
  logic [MS_W-1:0]   in_ms;
  logic              in_mode;
  logic [NOW_W-1:0]  in_now;
  logic [31:0]       in_prod;
  logic              in_acc;
  logic              in_known;

  assign in_req  = s_axis_tuser;
  assign in_id   = s_axis_tdata[3:0];
  assign in_ms   = s_axis_tdata[27:4];
  assign in_mode = s_axis_tdata[28];
  assign in_now  = s_axis_tdata[60:29];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_known      = in_req inside {[REQ_TICK:REQ_QUERY]};
  assign in_prod       = 32'(in_ms) * 32'(TICKS_PER_MS);

  // ring of slot cells
  slot_rec_t cell_q [NUM_TIMERS];
  step_t     step;
  logic      out_free;
  logic      step_en;
  logic      walk_last;

  assign out_free  = !out_valid_q || m_axis_tready;
  assign step_en   = (state_q == S_WALK) && !(step.expire && pend_v_q && !out_free);
  assign walk_last = (cnt_q == CNT_W'(NUM_TIMERS - 1));

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    slot_rec_t nxt;
    if (i == NUM_TIMERS - 1) begin : g_tail
      assign nxt = step.rec;
    end else begin : g_mid
      assign nxt = cell_q[i+1];
    end
    tmp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (step_en),
      .rec_i   (nxt),
      .rec_o   (cell_q[i])
    );
  end

  tmp_step u_step (
    .cmd_i   (cmd_q),
    .rec_i   (cell_q[0]),
    .cnt_i   (cnt_q),
    .found_i (found_q),
    .res_o   (step)
  );

  // divider for the query answer
  logic              div_start;
  logic              div_done;
  logic [TICK_W-1:0] div_quot;

  assign div_start = (state_q == S_DSTART);

  tmp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rem_cap_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // result writes: pending expiry during the walk, final result at the end
  logic walk_wr;
  logic done_wr;
  logic done_quiet;
  logic out_wr;

  assign walk_wr    = step_en && step.expire && pend_v_q;
  assign done_quiet = (state_q == S_DONE) && (cmd_q.req == REQ_TICK) && !pend_v_q;
  assign done_wr    = (state_q == S_DONE) && out_free && !done_quiet;
  assign out_wr     = walk_wr || done_wr;

  // sequencer and walk bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      prev_q   <= '0;
      cnt_q    <= '0;
      found_q  <= 1'b0;
      valid_q  <= 1'b0;
      run_q    <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cnt_q    <= '0;
            found_q  <= 1'b0;
            valid_q  <= 1'b0;
            run_q    <= 1'b0;
            pend_v_q <= 1'b0;
            if (in_req == REQ_TICK) begin
              prev_q <= in_now;
            end
            if (in_known && !(in_req == REQ_TICK && in_now == prev_q)) begin
              state_q <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (step_en) begin
            cnt_q <= cnt_q + CNT_W'(1);
            if (step.match) begin
              valid_q <= cell_q[0].used;
              run_q   <= cell_q[0].used && (cell_q[0].total != '0);
            end
            if (step.grab) begin
              found_q <= 1'b1;
            end
            if (step.expire) begin
              pend_v_q <= 1'b1;
            end
            if (walk_last) begin
              state_q <= (cmd_q.req == REQ_QUERY) ? S_DSTART : S_DONE;
            end
          end
        end
        S_DSTART: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (done_quiet || done_wr) begin
            pend_v_q <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // command and captured slot data
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q.req     <= req_e'(in_req);
      cmd_q.id      <= in_id;
      cmd_q.ticks   <= in_prod[TICK_W-1:0];
      cmd_q.mode    <= in_mode;
      cmd_q.elapsed <= in_now - prev_q;
    end
    if (step_en && step.match) begin
      rem_cap_q <= cell_q[0].rem;
    end
    if (step_en && step.grab) begin
      found_id_q <= ID_W'(cnt_q);
    end
    if (step_en && step.expire) begin
      pend_id_q <= ID_W'(cnt_q);
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_wr) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (walk_wr) begin
      out_kind_q   <= KIND_EXPIRY;
      out_slot_q   <= pend_id_q;
      out_status_q <= ST_OK;
      out_run_q    <= 1'b0;
      out_left_q   <= '0;
      out_last_q   <= 1'b0;
    end else if (done_wr) begin
      out_last_q <= 1'b1;
      out_run_q  <= 1'b0;
      out_left_q <= '0;
      case (cmd_q.req)
        REQ_TICK: begin
          out_kind_q   <= KIND_EXPIRY;
          out_slot_q   <= pend_id_q;
          out_status_q <= ST_OK;
        end
        REQ_ALLOC: begin
          out_kind_q   <= KIND_RESP;
          out_slot_q   <= found_q ? found_id_q : '0;
          out_status_q <= found_q ? ST_OK : ST_NO_FREE;
        end
        REQ_QUERY: begin
          out_kind_q   <= KIND_RESP;
          out_slot_q   <= cmd_q.id;
          out_status_q <= valid_q ? ST_OK : ST_NOT_ALLOC;
          out_run_q    <= run_q;
          out_left_q   <= run_q ? div_quot[LEFT_W-1:0] : '0;
        end
        default: begin
          out_kind_q   <= KIND_RESP;
          out_slot_q   <= cmd_q.id;
          out_status_q <= valid_q ? ST_OK : ST_NOT_ALLOC;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {1'b0, out_left_q, out_run_q, out_status_q, out_slot_q};

  // checks
  `TMP_ASSERT(a_state_onehot, $onehot(state_q), "sequencer state not one-hot")
  `TMP_ASSERT(a_no_overwrite, out_wr |-> (!out_valid_q || m_axis_tready),
    "result register overwritten before transfer")
  `TMP_ASSERT_NEVER(a_pend_in_idle, s_axis_tready && pend_v_q,
    "expiry still pending while taking a new item")
  `TMP_ASSERT(a_div_done_state, div_done |-> (state_q == S_DIV),
    "divider finished outside the divide state")

endmodule

`default_nettype wire

[src/tmp_cell.sv]
// one storage cell of the slot ring
// depends on tmp_pkg for the slot record type
`default_nettype none

module tmp_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  tmp_pkg::slot_rec_t rec_i,
  output tmp_pkg::slot_rec_t rec_o
);
  import tmp_pkg::*;

  slot_rec_t rec_q;

  // take the neighbor's record on every ring step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else if (shift_i) begin
      rec_q <= rec_i;
    end
  end

  assign rec_o = rec_q;

endmodule

`default_nettype wire

[src/tmp_step.sv]
// update unit at the head of the slot ring
// depends on tmp_pkg for command, record and step types
`default_nettype none

module tmp_step (
  input  tmp_pkg::cmd_t           cmd_i,
  input  tmp_pkg::slot_rec_t      rec_i,
  input  logic [tmp_pkg::CNT_W-1:0] cnt_i,
  input  logic                    found_i,
  output tmp_pkg::step_t          res_o
);
  import tmp_pkg::*;

  logic              in_lim;
  logic              match;
  logic              hit;
  logic              live;
  logic              ge;
  logic [TICK_W-1:0] rem_sub;
  logic [TICK_W-1:0] nrem;

  // slot addressing and activity
  assign in_lim = 32'(cnt_i) < 32'(SLOT_LIMIT);
  assign match  = in_lim && (32'(cmd_i.id) == 32'(cnt_i));
  assign hit    = match && rec_i.used;
  assign live   = in_lim && rec_i.used && (rec_i.total != '0);

  // saturating countdown by the elapsed ticks
  assign ge      = {1'b0, rec_i.rem} >= cmd_i.elapsed;
  assign rem_sub = rec_i.rem - cmd_i.elapsed[TICK_W-1:0];
  assign nrem    = ge ? rem_sub : '0;

  // per-request record update
  always_comb begin
    res_o       = '0;
    res_o.rec   = rec_i;
    res_o.match = match;
    case (cmd_i.req)
      REQ_TICK: begin
        if (live) begin
          if (nrem == '0) begin
            res_o.expire = 1'b1;
            if (rec_i.periodic) begin
              res_o.rec.rem = rec_i.total;
            end else begin
              res_o.rec.rem   = '0;
              res_o.rec.total = '0;
            end
          end else begin
            res_o.rec.rem = nrem;
          end
        end
      end
      REQ_ALLOC: begin
        if (in_lim && !found_i && !rec_i.used) begin
          res_o.grab = 1'b1;
          res_o.rec  = '{used: 1'b1, periodic: 1'b0, total: '0, rem: '0};
        end
      end
      REQ_FREE: begin
        if (hit) begin
          res_o.rec = '0;
        end
      end
      REQ_START: begin
        if (hit) begin
          res_o.rec.periodic = cmd_i.mode;
          res_o.rec.total    = cmd_i.ticks;
          res_o.rec.rem      = cmd_i.ticks;
        end
      end
      REQ_STOP: begin
        if (hit) begin
          res_o.rec.periodic = 1'b0;
          res_o.rec.total    = '0;
          res_o.rec.rem      = '0;
        end
      end
      default: begin
        res_o.rec = rec_i;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/tmp_div.sv]
// constant divider: remaining ticks to milliseconds by reciprocal multiply
// quotient registered on start and valid in the next cycle; depends on tmp_pkg for widths
`default_nettype none

module tmp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tmp_pkg::TICK_W-1:0] dividend_i,
  output logic                       done_o,
  output logic [tmp_pkg::TICK_W-1:0] quot_o
);
  import tmp_pkg::*;

  logic                      done_q;
  logic [TICK_W-1:0]         quot_q;
  logic [TICK_W+DIV_M_W-1:0] prod;

  // multiply by the rounded-up reciprocal, the quotient is the high part
  assign prod = {{DIV_M_W{1'b0}}, dividend_i} * {{TICK_W{1'b0}}, DIV_MAGIC};

  // done flag is start delayed by one register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  // quotient register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= TICK_W'(prod >> DIV_SHIFT);
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire
